// File: rtl/crps_pkg.sv
// Package: item types, register indexes and limits for the clipped read pattern search.
`timescale 1ns / 1ps
`default_nettype none

package crps_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_PAT_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PAT_HIGH    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PAT_LEN     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_LEN     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_IGNORE_CLIP = 3'd4;

  // Pattern storage is fixed by the register map: 16 characters
  localparam int unsigned PatStoreChars = 16;

  // Base position saturates here; no match can end at or past it
  localparam logic [15:0] POS_LIMIT = 16'hFFFF;
  // Right window bound meaning "end of read"
  localparam logic [16:0] RIGHT_OPEN = 17'h10000;

  localparam logic [15:0] KEY_LEN_RESET = 16'd4;

  typedef struct packed {
    logic [7:0]  base_char;
    logic        last_base;
    logic [15:0] quality_clip_left;
    logic [15:0] quality_clip_right;
    logic [15:0] adapter_clip_left;
    logic [15:0] adapter_clip_right;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] match_offset;
    logic [31:0] matched_reads;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// File: rtl/crps_stream_if.sv
// Valid/ready channel interface carrying one payload item per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface crps_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/clipped_read_pattern_search.sv
// Clipped read pattern search: streams read bases, reports a pattern hit per read.
//
// Channels: in_ch takes one base per item with the read's clip values and a
// last-base flag. out_ch gives one result (found, offset from the window start,
// saturating count of matched reads) for each read, after its last base.
// cfg_ch writes registers 0..4 (pattern low/high chars, pattern length, key
// length, ignore-clipping); it is always ready and must only be used while idle.
// Throughput: one base per cycle unless in_ch stalls as below. Each base
// is held in the input register; the window compare (one comparator per
// pattern length and offset) and the per-read state update run between that
// register and the state and result registers. A read's last base goes through
// the input register; its result then loads the result register behind out_ch.
// A waiting result does not block new bases; only a second last base stalls in
// the input register while the previous result is still not taken, and in_ch
// ready then drops.
// Reset clears the config registers, valid flags, position, hit state and match
// count; key length resets to 4, everything else to 0. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module clipped_read_pattern_search
  import crps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_CHARS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  crps_stream_if.sink   in_ch,
  crps_stream_if.source out_ch,
  crps_stream_if.sink   cfg_ch
);

  localparam int unsigned MaxW = 5;
  localparam logic [MaxW-1:0] MaxLen = MaxW'(MAX_PATTERN_CHARS);

  // Configuration registers
  logic [63:0] pat_low_q, pat_high_q;
  logic [4:0]  pat_len_q;
  logic [15:0] key_len_q;
  logic        ignore_clip_q;

  cfg_wr_t cfg_wr;
  assign cfg_wr = cfg_ch.payload;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q     <= '0;
      pat_high_q    <= '0;
      pat_len_q     <= '0;
      key_len_q     <= KEY_LEN_RESET;
      ignore_clip_q <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_wr.index)
        REG_PAT_LOW:     pat_low_q     <= cfg_wr.data;
        REG_PAT_HIGH:    pat_high_q    <= cfg_wr.data;
        REG_PAT_LEN:     pat_len_q     <= cfg_wr.data[4:0];
        REG_KEY_LEN:     key_len_q     <= cfg_wr.data[15:0];
        REG_IGNORE_CLIP: ignore_clip_q <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  logic [PatStoreChars-1:0][7:0] pat_chars;
  assign pat_chars = {pat_high_q, pat_low_q};

  // Input register
  logic     s1_valid_q;
  in_item_t s1_q;
  logic     s1_adv;
  logic     out_valid_q;
  out_item_t out_q;
  logic     out_load;

  assign s1_adv = s1_valid_q && (!s1_q.last_base || !out_valid_q || out_ch.ready);
  assign in_ch.ready = !s1_valid_q || s1_adv;
  assign out_load = s1_adv && s1_q.last_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_q <= in_ch.payload;
    end
  end

  // Per-read state
  logic [MAX_PATTERN_CHARS-1:0][7:0] win_q, win_d;
  logic [15:0] pos_q, pos_d;
  logic        hit_q, hit_d;
  logic [15:0] hoff_q, hoff_d;
  logic [31:0] cnt_q, cnt_d;

  logic [MaxW-1:0] plen_u;
  logic [15:0] qbase, left;
  logic [16:0] right, qr_a, qr_b, pos1;
  logic        cand, match, hit_new, found;
  logic [15:0] off_new;
  logic [MAX_PATTERN_CHARS:1] match_by_len;

  // Window bounds, candidate test and compare against every pattern length
  always_comb begin
    // shift in the new base, newest at index 0
    win_d[0] = s1_q.base_char;
    for (int k = 1; k < MAX_PATTERN_CHARS; k++) begin
      win_d[k] = win_q[k-1];
    end

    plen_u = (pat_len_q > MaxLen) ? MaxLen : pat_len_q;

    // left bound, clamped at zero
    qbase = (s1_q.quality_clip_left > s1_q.adapter_clip_left) ? key_len_q
                                                              : s1_q.quality_clip_left;
    left = (qbase != 16'd0) ? qbase - 16'd1 : 16'd0;
    // right bound; unset clips mean end of read
    qr_a = (s1_q.quality_clip_right == 16'd0) ? RIGHT_OPEN : {1'b0, s1_q.quality_clip_right};
    qr_b = (s1_q.adapter_clip_right == 16'd0) ? RIGHT_OPEN : {1'b0, s1_q.adapter_clip_right};
    if (s1_q.adapter_clip_left != 16'd0) begin
      right = {1'b0, s1_q.adapter_clip_left - 16'd1};
    end else begin
      right = (qr_a < qr_b) ? qr_a : qr_b;
    end
    if (ignore_clip_q) begin
      left  = '0;
      right = RIGHT_OPEN;
    end

    pos1 = {1'b0, pos_q} + 17'd1;
    cand = !hit_q && (plen_u != '0) && (pos_q != POS_LIMIT)
        && (pos1 >= 17'(plen_u)) && (pos1 <= right)
        && ((pos1 - 17'(plen_u)) >= {1'b0, left});

    // fixed comparator sets, one per pattern length
    for (int l = 1; l <= MAX_PATTERN_CHARS; l++) begin
      match_by_len[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (win_d[k] != pat_chars[l-1-k]) begin
          match_by_len[l] = 1'b0;
        end
      end
    end
    match = 1'b0;
    for (int l = 1; l <= MAX_PATTERN_CHARS; l++) begin
      if (plen_u == MaxW'(l)) begin
        match = match_by_len[l];
      end
    end

    hit_new = hit_q || (cand && match);
    off_new = hit_q ? hoff_q : (pos1[15:0] - 16'(plen_u) - left);
    found   = hit_new || (plen_u == '0);

    // next state; a last base closes the read
    cnt_d  = (found && s1_q.last_base && (cnt_q != '1)) ? cnt_q + 32'd1 : cnt_q;
    pos_d  = s1_q.last_base ? 16'd0 : ((pos_q == POS_LIMIT) ? pos_q : pos_q + 16'd1);
    hit_d  = s1_q.last_base ? 1'b0 : hit_new;
    hoff_d = s1_q.last_base ? 16'd0 : (hit_new ? off_new : 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hit_q  <= 1'b0;
      hoff_q <= '0;
      cnt_q  <= '0;
    end else if (s1_adv) begin
      pos_q  <= pos_d;
      hit_q  <= hit_d;
      hoff_q <= hoff_d;
      cnt_q  <= cnt_d;
    end
  end

  // base history; bytes older than the read are never compared
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q <= win_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.found         <= found;
      out_q.match_offset  <= hit_new ? off_new : 16'd0;
      out_q.matched_reads <= cnt_d;
    end
  end

  assign out_ch.valid   = out_valid_q;
  assign out_ch.payload = out_q;

  // Checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ch.ready |-> s1_valid_q && s1_q.last_base && out_valid_q)
    else $error("input stalled without a pending last base");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> cnt_q >= $past(cnt_q))
    else $error("matched read count went backwards");

  a_read_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> pos_q == 16'd0 && !hit_q && hoff_q == 16'd0)
    else $error("per-read state not cleared after last base");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && out_q.matched_reads == cnt_q)
    else $error("result count differs from stored count");

  a_no_offset_without_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.match_offset == 16'd0)
    else $error("nonzero offset on a miss");

endmodule

`default_nettype wire
